// ===== sv/hex_color_code_parser_core_macros.svh =====
// ----------------------------------------------------------------------------
// Hex color code parser - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HEX_COLOR_CODE_PARSER_CORE_MACROS_SVH
`define HEX_COLOR_CODE_PARSER_CORE_MACROS_SVH

// Same-cycle implication.
`define HCCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HCCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/hccp_pkg.sv =====
// ----------------------------------------------------------------------------
// Hex color code parser - package
// Field widths, character codes and character class helpers.
// ----------------------------------------------------------------------------
package hccp_pkg;

  localparam int CharW   = 8;
  localparam int ColorW  = 24;
  localparam int CountW  = 4;
  localparam int DigitW  = 4;
  localparam int TailLen = 6;

  localparam logic [CountW-1:0] KeptMax  = 4'd9;
  localparam logic [CountW-1:0] ShortLen = 4'd3;
  localparam logic [CountW-1:0] LongLen  = 4'd6;

  localparam logic [CharW-1:0] ChZero = 8'h30;
  localparam logic [CharW-1:0] ChXLo  = 8'h78;
  localparam logic [CharW-1:0] ChXUp  = 8'h58;
  localparam logic [CharW-1:0] ChHash = 8'h23;
  localparam logic [CharW-1:0] ChSp   = 8'h20;
  localparam logic [CharW-1:0] ChTab  = 8'h09;
  localparam logic [CharW-1:0] ChCr   = 8'h0D;

  typedef logic [CharW-1:0] char_t;

  // {not_hex, value}
  typedef logic [DigitW:0] digit_t;

  function automatic logic is_space(input char_t c);
    return (c == ChSp) || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic digit_t hex_digit(input char_t c);
    digit_t d;
    d = {1'b1, {DigitW{1'b0}}};
    if (c >= 8'h30 && c <= 8'h39) begin
      d = {1'b0, DigitW'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = {1'b0, DigitW'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = {1'b0, DigitW'(c - 8'h37)};
    end
    return d;
  endfunction

endpackage

// ===== sv/hccp_text_if.sv =====
// ----------------------------------------------------------------------------
// Hex color code parser - text channel
// Valid/ready channel carrying one character or an end marker.
// ----------------------------------------------------------------------------
interface hccp_text_if;
  logic                 valid;
  logic                 ready;
  hccp_pkg::char_t      char_code;
  logic                 end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

// ===== sv/hccp_result_if.sv =====
// ----------------------------------------------------------------------------
// Hex color code parser - result channel
// Valid/ready channel carrying the verdict and the parsed RGB value.
// ----------------------------------------------------------------------------
interface hccp_result_if;
  logic                        valid;
  logic                        ready;
  logic                        valid_res;
  logic [hccp_pkg::ColorW-1:0] color;

  modport source (output valid, output valid_res, output color, input ready);
  modport sink   (input valid, input valid_res, input color, output ready);
endinterface

// ===== sv/hex_color_code_parser_core.sv =====
// ----------------------------------------------------------------------------
// Hex color code parser - top level
// Parses "#RGB", "RRGGBB", "0x#RRGGBB" style text into a 24-bit color.
// ----------------------------------------------------------------------------
// Usage:
//   text   : one transaction per character (char_code), or an end marker
//            (end_of_text = 1, char_code ignored). Leading and trailing
//            whitespace is skipped; whitespace inside the code fails it.
//   result : exactly one transaction per end marker, carrying valid_res and
//            color (0xRRGGBB, zero when valid_res is 0). Character
//            transactions produce nothing on this channel.
//   Output: the result is presented in the cycle after the end marker is
//            taken; it comes straight from the single result register.
//   Throughput: one text transaction per cycle, sustained, as long as the
//            result side keeps up; each character only updates counters,
//            the three-entry head buffer and the six-entry tail shift line.
//   Stall: while a result waits on result.ready, text.ready drops; it stays
//            high whenever the result register is empty or being drained.
//   Reset: rst (synchronous) clears the character count, the whitespace and
//            error flags and the result valid flag. No clearing pass is needed.
//   After every end marker the parser returns to its reset state.
// ----------------------------------------------------------------------------
`include "hex_color_code_parser_core_macros.svh"

module hex_color_code_parser_core (
  input  logic                 clk,
  input  logic                 rst,
  hccp_text_if.sink            text,
  hccp_result_if.source        result
);

  // Parser state
  logic [hccp_pkg::CountW-1:0] kept_count;
  logic                        content_started;
  logic                        trailing_space_seen;
  logic                        text_bad;

  // First three kept characters (for the 0x prefix and '#'),
  // and the last six kept characters (the digits), newest at index 0.
  hccp_pkg::char_t             head0, head1, head2;
  hccp_pkg::char_t             tail [hccp_pkg::TailLen];

  // Result register
  logic                        res_vld;
  logic                        res_ok;
  logic [hccp_pkg::ColorW-1:0] res_color;

  logic take;
  logic take_end;
  logic take_char;
  logic char_is_space;
  logic keep_char;

  assign text.ready    = !res_vld || result.ready;
  assign take          = text.valid && text.ready;
  assign take_end      = take && text.end_of_text;
  assign take_char     = take && !text.end_of_text;
  assign char_is_space = hccp_pkg::is_space(text.char_code);
  assign keep_char     = take_char && !char_is_space;

  // --------------------------------------------------------------------------
  // Evaluate the kept text (used only when an end marker is taken)
  // --------------------------------------------------------------------------
  logic                        has_prefix;
  logic                        has_hash;
  logic [hccp_pkg::CountW-1:0] digit_len;
  logic                        is_short;
  logic                        is_long;
  hccp_pkg::digit_t            dig [hccp_pkg::TailLen];
  logic                        short_hex;
  logic                        long_hex;
  logic                        eval_ok;
  logic [hccp_pkg::ColorW-1:0] eval_color;

  always_comb begin
    has_prefix = (kept_count >= 4'd2) && (head0 == hccp_pkg::ChZero) &&
                 ((head1 == hccp_pkg::ChXLo) || (head1 == hccp_pkg::ChXUp));
    // '#' sits right after the prefix, or first when there is none
    if (has_prefix) begin
      has_hash = (kept_count > 4'd2) && (head2 == hccp_pkg::ChHash);
    end else begin
      has_hash = (kept_count != 4'd0) && (head0 == hccp_pkg::ChHash);
    end
    digit_len = kept_count - (has_prefix ? 4'd2 : 4'd0) - {3'b000, has_hash};
    is_short  = (digit_len == hccp_pkg::ShortLen);
    is_long   = (digit_len == hccp_pkg::LongLen);

    // Digits are always the last kept characters, so read fixed taps
    for (int i = 0; i < hccp_pkg::TailLen; i++) begin
      dig[i] = hccp_pkg::hex_digit(tail[i]);
    end
    short_hex = !dig[0][hccp_pkg::DigitW] && !dig[1][hccp_pkg::DigitW] &&
                !dig[2][hccp_pkg::DigitW];
    long_hex  = short_hex && !dig[3][hccp_pkg::DigitW] &&
                !dig[4][hccp_pkg::DigitW] && !dig[5][hccp_pkg::DigitW];

    eval_ok = !text_bad && ((is_short && short_hex) || (is_long && long_hex));

    if (!eval_ok) begin
      eval_color = '0;
    end else if (is_short) begin
      // Double each digit: ABC -> AABBCC
      eval_color = {dig[2][3:0], dig[2][3:0], dig[1][3:0], dig[1][3:0],
                    dig[0][3:0], dig[0][3:0]};
    end else begin
      eval_color = {dig[5][3:0], dig[4][3:0], dig[3][3:0],
                    dig[2][3:0], dig[1][3:0], dig[0][3:0]};
    end
  end

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count          <= '0;
      content_started     <= 1'b0;
      trailing_space_seen <= 1'b0;
      text_bad            <= 1'b0;
      res_vld             <= 1'b0;
    end else begin
      // Hold the result until taken; load a new one on an end marker
      if (take_end) begin
        res_vld <= 1'b1;
      end else if (result.ready) begin
        res_vld <= 1'b0;
      end

      if (take_end) begin
        // Drop all text state, ready for the next code
        kept_count          <= '0;
        content_started     <= 1'b0;
        trailing_space_seen <= 1'b0;
        text_bad            <= 1'b0;
      end else if (take_char && char_is_space) begin
        if (content_started) begin
          trailing_space_seen <= 1'b1;
        end
      end else if (keep_char) begin
        content_started <= 1'b1;
        if (trailing_space_seen) begin
          text_bad <= 1'b1;
        end
        if (kept_count < hccp_pkg::KeptMax) begin
          kept_count <= kept_count + 4'd1;
        end else begin
          text_bad <= 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Character buffers and result payload
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (keep_char && (kept_count < hccp_pkg::KeptMax)) begin
      if (kept_count == 4'd0) begin
        head0 <= text.char_code;
      end
      if (kept_count == 4'd1) begin
        head1 <= text.char_code;
      end
      if (kept_count == 4'd2) begin
        head2 <= text.char_code;
      end
      // Advance the tail shift line
      tail[0] <= text.char_code;
      for (int i = 1; i < hccp_pkg::TailLen; i++) begin
        tail[i] <= tail[i-1];
      end
    end
    if (take_end) begin
      res_ok    <= eval_ok;
      res_color <= eval_color;
    end
  end

  assign result.valid     = res_vld;
  assign result.valid_res = res_ok;
  assign result.color     = res_color;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `HCCP_ASSERT_NEXT(a_end_gives_result, take_end, res_vld, "end marker gave no result")
  `HCCP_ASSERT_NEXT(a_end_clears_count, take_end, kept_count == '0, "count not cleared")
  `HCCP_ASSERT_NOW(a_count_bound, 1'b1, kept_count <= hccp_pkg::KeptMax, "count overflow")
  `HCCP_ASSERT_NOW(a_bad_color_zero, res_vld && !res_ok, res_color == '0, "invalid nonzero")
  `HCCP_ASSERT_NOW(a_ready_when_empty, !res_vld, text.ready, "not ready while empty")

endmodule
